// File: rtl/sprr_pkg.sv
// Shared constants and types for the sprite run span renderer.
// No dependencies; used by the top level, the span checker and the testbench.
package sprr_pkg;

  // Sprite edge length in cells
  localparam int SPRITE_DIM = 9;
  localparam int COL_W      = (SPRITE_DIM > 1) ? $clog2(SPRITE_DIM) : 1;

  // Result queue
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // Cell codes
  localparam logic [7:0] CODE_ZERO  = 8'h30;
  localparam logic [7:0] CODE_FIRST = 8'h31;
  localparam logic [7:0] CODE_LAST  = 8'h35;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_ORIGIN_X      = 3'd0,
    REG_ORIGIN_Y      = 3'd1,
    REG_PIXEL_SCALE   = 3'd2,
    REG_SCREEN_WIDTH  = 3'd3,
    REG_PAL_ONE_TWO   = 3'd4,
    REG_PAL_THREE_FOUR = 3'd5,
    REG_PAL_FIVE      = 3'd6
  } cfg_idx_t;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 48;

  // Color index of a run (code minus '0')
  localparam logic [2:0] COLOR_1 = 3'd1;
  localparam logic [2:0] COLOR_2 = 3'd2;
  localparam logic [2:0] COLOR_3 = 3'd3;
  localparam logic [2:0] COLOR_4 = 3'd4;
  localparam logic [2:0] COLOR_5 = 3'd5;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [6:0]  w;
    logic [1:0]  h;
    logic [15:0] color;
    logic        last;
  } rect_t;

  typedef struct packed {
    logic  vis;
    rect_t r;
  } cand_t;

endpackage

// File: rtl/sprite_run_span_renderer.sv
// Sprite run span renderer top level: input register, run merge logic, result queue.
// Depends on sprr_pkg.
//
// Takes one sprite cell word per cycle (in_valid high, in_stall low) and
// emits one rectangle word per run that ends and is horizontally visible.
// A cell waits in the input register until there is room for its rectangles,
// which are then written into a four-entry result queue and are offered on
// the out_ channel once written. The input side sustains one cell per
// clock as long as the queue has room for two words; a cell at the end of
// a row can yield two rectangles, which leave the queue one at a time.
module sprite_run_span_renderer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [sprr_pkg::CFG_AW-1:0]  cfg_index,
  input  logic [sprr_pkg::CFG_DW-1:0]  cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   in_cell_code,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [15:0]           out_rect_x,
  output logic signed [15:0]           out_rect_y,
  output logic [6:0]                   out_rect_width,
  output logic [1:0]                   out_rect_height,
  output logic [15:0]                  out_fill_color,
  output logic                         out_last_of_run
);

  localparam int CW  = sprr_pkg::COL_W;
  localparam int CW1 = CW + 1;
  localparam int QA  = sprr_pkg::Q_AW;
  localparam int QC  = sprr_pkg::Q_CW;

  // configuration
  logic [15:0] origin_x_r, origin_y_r;
  logic [1:0]  scale_r;
  logic [11:0] screen_w_r;
  logic [47:0] pal12_r, pal34_r;
  logic [23:0] pal5_r;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_code_r;

  // run state
  logic [CW-1:0] col_r, row_r, start_r;
  logic [2:0]    color_r;
  logic          open_r;

  // result queue
  sprr_pkg::rect_t q_mem_r [sprr_pkg::Q_DEPTH];
  logic [QA-1:0] wr_ptr_r, rd_ptr_r;
  logic [QC-1:0] cnt_r;

  logic          go, accept, pop;
  logic          colored, close_a, cont, row_end, a_vis, b_vis;
  logic [7:0]    code_diff;
  logic [2:0]    idx;
  logic [CW-1:0] start_b;
  logic [QA-1:0] b_idx;
  sprr_pkg::cand_t cand_a, cand_b;
  sprr_pkg::rect_t wr_a, wr_b;

  function automatic sprr_pkg::cand_t emit(
    input logic [CW-1:0]  start,
    input logic [CW1-1:0] endc,
    input logic [2:0]     code,
    input logic [CW-1:0]  row
  );
    logic [1:0]      s;
    logic [CW1-1:0]  len;
    logic [7:0]      pw8, sx8, sy8;
    logic [18:0]     px, pend, py;
    logic [23:0]     rgb;
    logic            lt_w, gt_0;
    sprr_pkg::cand_t c;
    s    = (scale_r == 2'd0) ? 2'd1 : scale_r;
    len  = endc - {1'b0, start};
    pw8  = 8'(len) * 8'(s);
    sx8  = 8'(start) * 8'(s);
    sy8  = 8'(row) * 8'(s);
    px   = {{3{origin_x_r[15]}}, origin_x_r} + {11'b0, sx8};
    py   = {{3{origin_y_r[15]}}, origin_y_r} + {11'b0, sy8};
    pend = px + {12'b0, pw8[6:0]};
    lt_w = $signed(px) < $signed({7'b0, screen_w_r});
    gt_0 = !pend[18] && (pend != 19'd0);
    case (code)
      sprr_pkg::COLOR_1: rgb = pal12_r[23:0];
      sprr_pkg::COLOR_2: rgb = pal12_r[47:24];
      sprr_pkg::COLOR_3: rgb = pal34_r[23:0];
      sprr_pkg::COLOR_4: rgb = pal34_r[47:24];
      sprr_pkg::COLOR_5: rgb = pal5_r;
      default: rgb = 24'd0;
    endcase
    c.vis     = (endc > {1'b0, start}) && lt_w && gt_0;
    c.r.x     = px[15:0];
    c.r.y     = py[15:0];
    c.r.w     = pw8[6:0];
    c.r.h     = s;
    c.r.color = {rgb[23:19], rgb[15:10], rgb[7:3]};
    c.r.last  = 1'b0;
    return c;
  endfunction

  assign go       = s1_valid_r && (cnt_r <= QC'(sprr_pkg::Q_DEPTH - 2));
  assign in_stall = s1_valid_r && !go;
  assign accept   = in_valid && !in_stall;
  assign out_valid = (cnt_r != '0);
  assign pop      = out_valid && !out_stall;

  always_comb begin
    colored   = (s1_code_r >= sprr_pkg::CODE_FIRST) && (s1_code_r <= sprr_pkg::CODE_LAST);
    code_diff = s1_code_r - sprr_pkg::CODE_ZERO;
    idx       = colored ? code_diff[2:0] : 3'd0;
    close_a   = open_r && (!colored || (idx != color_r));
    cont      = open_r && !close_a;
    start_b   = cont ? start_r : col_r;
    row_end   = (col_r == CW'(sprr_pkg::SPRITE_DIM - 1));
    cand_a    = emit(start_r, {1'b0, col_r}, color_r, row_r);
    cand_b    = emit(start_b, CW1'(sprr_pkg::SPRITE_DIM), idx, row_r);
    a_vis     = go && close_a && cand_a.vis;
    b_vis     = go && row_end && colored && cand_b.vis;
    wr_a      = cand_a.r;
    wr_a.last = !b_vis;
    wr_b      = cand_b.r;
    wr_b.last = 1'b1;
    b_idx     = a_vis ? wr_ptr_r + QA'(1) : wr_ptr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      scale_r    <= 2'd1;
      screen_w_r <= 12'd64;
      pal12_r    <= '0;
      pal34_r    <= '0;
      pal5_r     <= '0;
      s1_valid_r <= 1'b0;
      col_r      <= '0;
      row_r      <= '0;
      start_r    <= '0;
      color_r    <= '0;
      open_r     <= 1'b0;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      cnt_r      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sprr_pkg::REG_ORIGIN_X:       origin_x_r <= cfg_wdata[15:0];
          sprr_pkg::REG_ORIGIN_Y:       origin_y_r <= cfg_wdata[15:0];
          sprr_pkg::REG_PIXEL_SCALE:    scale_r    <= cfg_wdata[1:0];
          sprr_pkg::REG_SCREEN_WIDTH:   screen_w_r <= cfg_wdata[11:0];
          sprr_pkg::REG_PAL_ONE_TWO:    pal12_r    <= cfg_wdata[47:0];
          sprr_pkg::REG_PAL_THREE_FOUR: pal34_r    <= cfg_wdata[47:0];
          sprr_pkg::REG_PAL_FIVE:       pal5_r     <= cfg_wdata[23:0];
          default: ;
        endcase
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (go) begin
        s1_valid_r <= 1'b0;
      end
      if (go) begin
        if (row_end) begin
          open_r <= 1'b0;
          col_r  <= '0;
          row_r  <= (row_r == CW'(sprr_pkg::SPRITE_DIM - 1)) ? '0 : row_r + CW'(1);
        end else begin
          open_r <= colored;
          col_r  <= col_r + CW'(1);
        end
        if (colored) begin
          start_r <= start_b;
          color_r <= idx;
        end
      end
      wr_ptr_r <= wr_ptr_r + QA'(a_vis) + QA'(b_vis);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QA'(1);
      end
      cnt_r <= QC'(cnt_r + QC'(a_vis) + QC'(b_vis) - QC'(pop));
    end
  end

  // input word register and queue storage, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_code_r <= in_cell_code;
    end
    if (a_vis) begin
      q_mem_r[wr_ptr_r] <= wr_a;
    end
    if (b_vis) begin
      q_mem_r[b_idx] <= wr_b;
    end
  end

  assign out_rect_x      = q_mem_r[rd_ptr_r].x;
  assign out_rect_y      = q_mem_r[rd_ptr_r].y;
  assign out_rect_width  = q_mem_r[rd_ptr_r].w;
  assign out_rect_height = q_mem_r[rd_ptr_r].h;
  assign out_fill_color  = q_mem_r[rd_ptr_r].color;
  assign out_last_of_run = q_mem_r[rd_ptr_r].last;

endmodule

// File: rtl/sprr_port_checker.sv
// Port-level checks for the sprite run span renderer, bound to its top level.
// Port widths are written out here; it does not depend on sprr_pkg.
module sprr_port_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic signed [15:0]          out_rect_x,
  input logic signed [15:0]          out_rect_y,
  input logic [6:0]                  out_rect_width,
  input logic [1:0]                  out_rect_height,
  input logic [15:0]                 out_fill_color,
  input logic                        out_last_of_run
);

  // a stalled result word holds (the height field is not checked here)
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rect_x) && $stable(out_rect_y)
      && $stable(out_rect_width) && $stable(out_fill_color) && $stable(out_last_of_run))
    else $error("result word changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_height: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rect_height != 2'd0)
    else $error("zero rectangle height");

  // width is a run length times the height, never below it
  a_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rect_width >= {5'd0, out_rect_height})
    else $error("rectangle narrower than its scale");

endmodule

bind sprite_run_span_renderer sprr_port_checker u_sprr_port_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_rect_x      (out_rect_x),
  .out_rect_y      (out_rect_y),
  .out_rect_width  (out_rect_width),
  .out_rect_height (out_rect_height),
  .out_fill_color  (out_fill_color),
  .out_last_of_run (out_last_of_run)
);

// File: test/sprite_span_checker.sv
// Span checker for the sprite run span renderer: follows config writes and accepted
// cell words, predicts the rectangle words and compares them on the out_ channel.
// Depends on sprr_pkg; instantiated beside the block by sprite_run_span_renderer_tb.
module sprite_span_checker
  import sprr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CFG_AW-1:0]   cfg_index,
  input  logic [CFG_DW-1:0]   cfg_wdata,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [7:0]          in_cell_code,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic signed [15:0]  out_rect_x,
  input  logic signed [15:0]  out_rect_y,
  input  logic [6:0]          out_rect_width,
  input  logic [1:0]          out_rect_height,
  input  logic [15:0]         out_fill_color,
  input  logic                out_last_of_run,
  output int                  fail_count,
  output int                  outstanding
);

  logic signed [15:0] org_x;
  logic signed [15:0] org_y;
  logic [1:0]         scale_r;
  logic [11:0]        scr_w;
  logic [47:0]        pal_12;
  logic [47:0]        pal_34;
  logic [23:0]        pal_5;

  logic [4:0] col_n;
  logic [4:0] row_n;
  logic [4:0] run_col;
  logic [2:0] run_clr;
  logic       run_on;

  rect_t rects_due[$];
  rect_t found[2];
  int    n_found;
  int    err_total = 0;

  assign fail_count = err_total;

  function automatic logic [15:0] to_rgb565(input logic [23:0] rgb);
    return {rgb[23:19], rgb[15:10], rgb[7:3]};
  endfunction

  function automatic logic [23:0] palette_of(input logic [2:0] clr);
    case (clr)
      COLOR_1: return pal_12[23:0];
      COLOR_2: return pal_12[47:24];
      COLOR_3: return pal_34[23:0];
      COLOR_4: return pal_34[47:24];
      COLOR_5: return pal_5;
      default: return 24'h0;
    endcase
  endfunction

  // Closes the open run before end_col; keeps it only if it reaches the screen.
  task automatic close_span(input int end_col);
    int    s;
    int    len;
    int    sx;
    int    sy;
    int    sw;
    int    px;
    int    py;
    int    pw;
    rect_t r;
    s   = (scale_r == 2'd0) ? 1 : int'(scale_r);
    sx  = org_x;
    sy  = org_y;
    sw  = scr_w;
    len = end_col - int'(run_col);
    px  = sx + int'(run_col) * s;
    pw  = len * s;
    py  = sy + int'(row_n) * s;
    run_on = 1'b0;
    if (len > 0 && px < sw && px + pw > 0) begin
      r.x     = px[15:0];
      r.y     = py[15:0];
      r.w     = pw[6:0];
      r.h     = s[1:0];
      r.color = to_rgb565(palette_of(run_clr));
      r.last  = 1'b0;
      found[n_found] = r;
      n_found++;
    end
  endtask

  task automatic predict_cell(input logic [7:0] code);
    logic       colored;
    logic [7:0] diff;
    logic [2:0] clr;
    int         col;
    colored = (code >= CODE_FIRST) && (code <= CODE_LAST);
    diff    = code - CODE_ZERO;
    clr     = colored ? diff[2:0] : 3'd0;
    col     = col_n;
    n_found = 0;
    if (run_on && (!colored || clr != run_clr)) close_span(col);
    if (colored && !run_on) begin
      run_on  = 1'b1;
      run_col = col_n;
      run_clr = clr;
    end
    if (col + 1 >= SPRITE_DIM) begin
      if (run_on) close_span(col + 1);
      col_n = 5'd0;
      row_n = (int'(row_n) + 1 >= SPRITE_DIM) ? 5'd0 : row_n + 5'd1;
    end else begin
      col_n = col_n + 5'd1;
    end
    if (n_found > 0) found[n_found-1].last = 1'b1;
    for (int i = 0; i < n_found; i++) rects_due.push_back(found[i]);
  endtask

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      err_total++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    rect_t want;
    if (!rst_n) begin
      org_x   = '0;
      org_y   = '0;
      scale_r = 2'd1;
      scr_w   = 12'd64;
      pal_12  = '0;
      pal_34  = '0;
      pal_5   = '0;
      col_n   = '0;
      row_n   = '0;
      run_col = '0;
      run_clr = '0;
      run_on  = 1'b0;
      rects_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ORIGIN_X:       org_x   = cfg_wdata[15:0];
          REG_ORIGIN_Y:       org_y   = cfg_wdata[15:0];
          REG_PIXEL_SCALE:    scale_r = cfg_wdata[1:0];
          REG_SCREEN_WIDTH:   scr_w   = cfg_wdata[11:0];
          REG_PAL_ONE_TWO:    pal_12  = cfg_wdata[47:0];
          REG_PAL_THREE_FOUR: pal_34  = cfg_wdata[47:0];
          REG_PAL_FIVE:       pal_5   = cfg_wdata[23:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_cell(in_cell_code);
      if (out_valid && !out_stall) begin
        if (rects_due.size() == 0) begin
          err_total++;
          $display("%0t: rectangle word with none expected, actual x=0x%0h y=0x%0h w=%0d",
                   $time, out_rect_x, out_rect_y, out_rect_width);
        end else begin
          want = rects_due.pop_front();
          check_field("rect_x", want.x, out_rect_x);
          check_field("rect_y", want.y, out_rect_y);
          check_field("rect_width", want.w, out_rect_width);
          check_field("rect_height", want.h, out_rect_height);
          check_field("fill_color", want.color, out_fill_color);
          check_field("last_of_run", want.last, out_last_of_run);
        end
      end
    end
    outstanding <= rects_due.size();
  end

endmodule

// File: test/sprite_run_span_renderer_tb.sv
// Testbench top for the sprite run span renderer: clock, reset, config phases,
// cell word stimulus with random gaps and output stalls, and the final verdict.
// Depends on sprr_pkg, sprite_run_span_renderer and sprite_span_checker.
module sprite_run_span_renderer_tb;
  import sprr_pkg::*;

  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_CELLS   = 140;
  localparam int PHASES        = 10;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CFG_AW-1:0]  cfg_index = '0;
  logic [CFG_DW-1:0]  cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_cell_code = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] out_rect_x;
  logic signed [15:0] out_rect_y;
  logic [6:0]         out_rect_width;
  logic [1:0]         out_rect_height;
  logic [15:0]        out_fill_color;
  logic               out_last_of_run;

  int fail_count;
  int outstanding;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_req = 1'b0;

  logic [7:0] directed_cells[20] = '{
    CODE_FIRST, CODE_FIRST, CODE_FIRST + 8'd1, CODE_ZERO, CODE_LAST, CODE_LAST,
    8'h00, 8'hFF, CODE_FIRST + 8'd2,
    CODE_FIRST + 8'd3, CODE_FIRST + 8'd3, CODE_FIRST + 8'd3, CODE_FIRST + 8'd3,
    CODE_FIRST + 8'd3, CODE_FIRST + 8'd3, CODE_FIRST + 8'd3, CODE_FIRST + 8'd3, CODE_LAST,
    CODE_LAST + 8'd1, CODE_ZERO - 8'd1
  };

  always #2 clk = ~clk;

  sprite_run_span_renderer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cell_code    (in_cell_code),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_rect_x      (out_rect_x),
    .out_rect_y      (out_rect_y),
    .out_rect_width  (out_rect_width),
    .out_rect_height (out_rect_height),
    .out_fill_color  (out_fill_color),
    .out_last_of_run (out_last_of_run)
  );

  sprite_span_checker span_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cell_code    (in_cell_code),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_rect_x      (out_rect_x),
    .out_rect_y      (out_rect_y),
    .out_rect_width  (out_rect_width),
    .out_rect_height (out_rect_height),
    .out_fill_color  (out_fill_color),
    .out_last_of_run (out_last_of_run),
    .fail_count      (fail_count),
    .outstanding     (outstanding)
  );

  function automatic int pick_gap(input int pct);
    if (int'($urandom_range(99)) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 10);
    return $urandom_range(3, 1);
  endfunction

  function automatic logic [7:0] pick_blank();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b >= CODE_FIRST && b <= CODE_LAST) b = b ^ 8'h80;
    return b;
  endfunction

  task automatic put_reg(input cfg_idx_t idx, input logic [CFG_DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] ox, input logic [15:0] oy,
                            input logic [1:0] sc, input logic [11:0] sw,
                            input logic [47:0] p12, input logic [47:0] p34,
                            input logic [23:0] p5);
    put_reg(REG_ORIGIN_X, ox);
    put_reg(REG_ORIGIN_Y, oy);
    put_reg(REG_PIXEL_SCALE, sc);
    put_reg(REG_SCREEN_WIDTH, sw);
    put_reg(REG_PAL_ONE_TWO, p12);
    put_reg(REG_PAL_THREE_FOUR, p34);
    put_reg(REG_PAL_FIVE, p5);
    cfg_we <= 1'b0;
  endtask

  task automatic phase_config(input int p);
    logic [15:0] ox;
    logic [15:0] oy;
    logic [1:0]  sc;
    logic [11:0] sw;
    logic [47:0] p12;
    logic [47:0] p34;
    logic [23:0] p5;
    ox  = 16'($urandom_range(120) - 50);
    oy  = 16'($urandom_range(80) - 20);
    sc  = 2'($urandom_range(3));
    p12 = 48'({$urandom, $urandom});
    p34 = 48'({$urandom, $urandom});
    p5  = 24'($urandom);
    case ($urandom_range(3))
      0, 1: sw = 12'($urandom_range(40, 1));
      2:    sw = 12'hFFF;
      default: sw = 12'($urandom_range(4095));
    endcase
    case (p)
      0: begin
        ox = 16'h0000; oy = 16'h7FFF; sc = 2'd3; sw = 12'hFFF;
        p12 = '1; p34 = '1; p5 = '1;
      end
      1: begin
        ox = 16'h8000; oy = 16'h8000; sc = 2'd1; sw = 12'hFFF;
        p12 = '0; p34 = '0; p5 = '0;
      end
      2: begin ox = 16'h7FFF; oy = 16'h0000; sc = 2'd2; sw = 12'hFFF; end
      3: begin ox = -16'sd5; oy = 16'($urandom); sc = 2'd0; sw = 12'd10; end
      4: begin ox = -16'sd10; sc = 2'd2; sw = 12'd0; end
      5: begin ox = 16'h0000; sc = 2'd1; sw = 12'd1; end
      default: ;
    endcase
    set_config(ox, oy, sc, sw, p12, p34, p5);
  endtask

  task automatic send_cell(input logic [7:0] code);
    int gap;
    gap = pick_gap(tx_idle_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cell_code <= code;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Mostly colored runs of random length, some spanning row ends, with blank noise.
  task automatic send_sprite_cells(input int count);
    int         sent;
    int         len;
    logic [7:0] code;
    sent = 0;
    while (sent < count) begin
      code = ($urandom_range(3) == 0) ? pick_blank() : CODE_FIRST + 8'($urandom_range(4));
      len  = ($urandom_range(7) == 0) ? $urandom_range(12, 7) : $urandom_range(4, 1);
      repeat (len) begin
        send_cell(code);
        sent++;
      end
    end
  endtask

  task automatic drain();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Output side stall pattern; a hold-off request parks it for a long stretch.
  initial begin
    int len;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (int'($urandom_range(99)) < rx_idle_pct) begin
        out_stall <= 1'b1;
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
        repeat (len) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        len = $urandom_range(6, 1);
        repeat (len) @(posedge clk);
      end
    end
  end

  initial begin
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    set_config(16'd3, -16'sd2, 2'd2, 12'd40, 48'h00FF00_FF0000, 48'hFFFF00_0000FF,
               24'h80C0E0);
    foreach (directed_cells[i]) send_cell(directed_cells[i]);
    in_valid <= 1'b0;
    drain();
    for (int p = 0; p < PHASES; p++) begin
      tx_idle_pct = (p % 3) * 25;
      rx_idle_pct = ((p + 1) % 3) * 25;
      phase_config(p);
      if (p == 5) hold_req = 1'b1;
      send_sprite_cells(PHASE_CELLS);
      in_valid <= 1'b0;
      drain();
    end
    if (fail_count == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
